/* sv/asrc_pkg.sv */
// ----------------------------------------------------------------------------
// asrc_pkg
// Shared constants for the adaptive sample rate controller:
// stream field layout, register indexes, reset values, rates and reason codes.
// ----------------------------------------------------------------------------
package asrc_pkg;

    // input fields
    localparam int TS_W      = 64;
    localparam int LAT_W     = 64;
    localparam int STATUS_W  = 10;
    localparam int RAND_W    = 32;

    localparam int TS_LSB     = 0;
    localparam int LAT_LSB    = TS_LSB + TS_W;
    localparam int STATUS_LSB = LAT_LSB + LAT_W;
    localparam int RAND_LSB   = STATUS_LSB + STATUS_W;
    localparam int S_DATA_BITS = RAND_LSB + RAND_W;
    localparam int S_TDATA_W  = ((S_DATA_BITS + 7) / 8) * 8;

    // result fields; rate_update travels on tuser
    localparam int RATE_W    = 7;
    localparam int QPS_W     = 32;
    localparam int PCT_W     = 7;
    localparam int REASON_W  = 3;

    localparam int SAMPLED_LSB = 0;
    localparam int OLD_LSB     = 1;
    localparam int NEW_LSB     = OLD_LSB + RATE_W;
    localparam int QPS_LSB     = NEW_LSB + RATE_W;
    localparam int PCT_LSB     = QPS_LSB + QPS_W;
    localparam int REASON_LSB  = PCT_LSB + PCT_W;
    localparam int M_DATA_BITS = REASON_LSB + REASON_W;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_QPS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_QPS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_PCT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LATENCY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_RATE  = 3'd5;

    localparam logic [31:0]       RST_WINDOW_LENGTH = 32'd1000000000;
    localparam logic [31:0]       RST_LOW_QPS       = 32'd1000;
    localparam logic [31:0]       RST_MEDIUM_QPS    = 32'd10000;
    localparam logic [PCT_W-1:0]  RST_ERROR_PCT     = 7'd5;
    localparam logic [31:0]       RST_SLOW_LATENCY  = 32'd1000000000;
    localparam logic [RATE_W-1:0] RST_DEFAULT_RATE  = 7'd100;

    localparam logic [STATUS_W-1:0] STATUS_ERROR = 10'd400;

    localparam logic [RATE_W-1:0] RATE_ALL    = 7'd1;
    localparam logic [RATE_W-1:0] RATE_TENTH  = 7'd10;
    localparam logic [RATE_W-1:0] RATE_SPARSE = 7'd100;

    localparam logic [REASON_W-1:0] REASON_NONE     = 3'd0;
    localparam logic [REASON_W-1:0] REASON_LOW_QPS  = 3'd1;
    localparam logic [REASON_W-1:0] REASON_MED_QPS  = 3'd2;
    localparam logic [REASON_W-1:0] REASON_ERRORS   = 3'd3;
    localparam logic [REASON_W-1:0] REASON_LATENCY  = 3'd4;

    // errors*100/requests and slow*20 > requests (slow share above 5 percent)
    localparam int PCT_SCALE = 100;
    localparam int LAT_SCALE = 20;

endpackage

/* sv/adaptive_sample_rate_controller_top.sv */
// ----------------------------------------------------------------------------
// adaptive_sample_rate_controller_top
// Windowed request statistics, target sampling rate selection and per-request
// sampling decision, run on one shared subtract/compare unit.
// ----------------------------------------------------------------------------
// Requests are taken one at a time; s_tready is high only in the idle state.
//   Error and slow requests skip the modulo; a request that closes a window
//   also runs the threshold compares and the restoring divide for the error
//   percentage. The 32-step modulo of the random word and the divide share
//   one subtractor.
// Reset: synchronous, active low; clears the window, counters and rates and
//   restores the register defaults.
// ----------------------------------------------------------------------------
module adaptive_sample_rate_controller_top #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // timestamp_ns, latency_ns, resp_status, random_word (zero padded)
    input  logic [asrc_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sampled, old_rate, chosen_rate, window_qps, error_percent,
    // reason_code (zero padded)
    output logic [asrc_pkg::M_TDATA_W-1:0]      m_tdata,
    // rate_update
    output logic                                m_tuser,
    input  logic                                cfg_we,
    input  logic [asrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [asrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = COUNT_WIDTH;
    localparam int UW = (CW + asrc_pkg::RATE_W > asrc_pkg::TS_W) ?
                        CW + asrc_pkg::RATE_W : asrc_pkg::TS_W;
    localparam int CNT_W = $clog2(asrc_pkg::RAND_W);
    localparam int RW = asrc_pkg::RATE_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SLOW   = 4'd1;
    localparam logic [3:0] ST_ELAPSE = 4'd2;
    localparam logic [3:0] ST_ROLL   = 4'd3;
    localparam logic [3:0] ST_LOWCMP = 4'd4;
    localparam logic [3:0] ST_MEDCMP = 4'd5;
    localparam logic [3:0] ST_PREP   = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_LAT    = 4'd8;
    localparam logic [3:0] ST_DECIDE = 4'd9;
    localparam logic [3:0] ST_COUNT  = 4'd10;
    localparam logic [3:0] ST_MOD    = 4'd11;
    localparam logic [3:0] ST_DONE   = 4'd12;

    // control state
    logic [3:0]               state_reg, state_next;
    logic [31:0]              wlen_reg, wlen_next;
    logic [31:0]              low_reg, low_next;
    logic [31:0]              med_reg, med_next;
    logic [asrc_pkg::PCT_W-1:0] pct_lim_reg, pct_lim_next;
    logic [31:0]              slow_lat_reg, slow_lat_next;
    logic [RW-1:0]            def_rate_reg, def_rate_next;
    logic [asrc_pkg::TS_W-1:0] wb_reg, wb_next;
    logic [CW-1:0]            req_reg, req_next;
    logic [CW-1:0]            err_reg, err_next;
    logic [CW-1:0]            slw_reg, slw_next;
    logic [RW-1:0]            cur_reg, cur_next;
    logic [RW-1:0]            target_reg, target_next;
    logic                     m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    // payload and working registers
    logic [asrc_pkg::TS_W-1:0]   ts_reg, ts_next;
    logic [asrc_pkg::LAT_W-1:0]  latency_reg, latency_next;
    logic [asrc_pkg::RAND_W-1:0] rnd_reg, rnd_next;
    logic                        err_flag_reg, err_flag_next;
    logic                        slow_flag_reg, slow_flag_next;
    logic [asrc_pkg::TS_W-1:0]   elapsed_reg, elapsed_next;
    logic                        roll_reg, roll_next;
    logic                        low_lt_reg, low_lt_next;
    logic                        med_lt_reg, med_lt_next;
    logic                        lat_hi_reg, lat_hi_next;
    logic [UW-1:0]               num_reg, num_next;
    logic [UW-1:0]               div_reg, div_next;
    logic [UW-1:0]               slow20_reg, slow20_next;
    logic [asrc_pkg::PCT_W-1:0]  pct_reg, pct_next;
    logic [RW-1:0]               eff_reg, eff_next;
    logic [RW-1:0]               rem_reg, rem_next;
    logic                        sampled_reg, sampled_next;
    logic                        upd_reg, upd_next;
    logic [RW-1:0]               old_reg, old_next;
    logic [RW-1:0]               new_reg, new_next;
    logic [asrc_pkg::QPS_W-1:0]  qps_reg, qps_next;
    logic [asrc_pkg::PCT_W-1:0]  res_pct_reg, res_pct_next;
    logic [asrc_pkg::REASON_W-1:0] reason_reg, reason_next;
    logic [asrc_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                        m_user_reg, m_user_next;

    // shared subtract/compare unit
    logic [UW-1:0] ua, ub;
    logic [UW:0]   udiff;
    logic          borrow;

    logic [RW:0]   rem_sh;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign rem_sh = {rem_reg, rnd_reg[asrc_pkg::RAND_W-1]};

    always_comb begin
        ua = '0;
        ub = '0;
        case (state_reg)
            ST_SLOW: begin
                ua = UW'(slow_lat_reg);
                ub = UW'(latency_reg);
            end
            ST_ELAPSE: begin
                ua = UW'(ts_reg);
                ub = UW'(wb_reg);
            end
            ST_ROLL: begin
                ua = UW'(wlen_reg);
                ub = UW'(elapsed_reg);
            end
            ST_LOWCMP: begin
                ua = UW'(req_reg);
                ub = UW'(low_reg);
            end
            ST_MEDCMP: begin
                ua = UW'(req_reg);
                ub = UW'(med_reg);
            end
            ST_DIV: begin
                ua = num_reg;
                ub = div_reg;
            end
            ST_LAT: begin
                ua = UW'(req_reg);
                ub = slow20_reg;
            end
            ST_MOD: begin
                ua = UW'(rem_sh);
                ub = UW'(eff_reg);
            end
            default: begin
                ua = '0;
                ub = '0;
            end
        endcase
    end

    assign udiff  = {1'b0, ua} - {1'b0, ub};
    assign borrow = udiff[UW];

    always_comb begin
        logic [RW-1:0]                 nr;
        logic [asrc_pkg::REASON_W-1:0] rsn;
        logic                          has;
        logic [UW-1:0]                 qps_ext;
        logic [CW-1:0]                 req_base, err_base, slw_base;
        logic [RW-1:0]                 cur_new;
        logic [RW-1:0]                 rem_new;

        state_next     = state_reg;
        wlen_next      = wlen_reg;
        low_next       = low_reg;
        med_next       = med_reg;
        pct_lim_next   = pct_lim_reg;
        slow_lat_next  = slow_lat_reg;
        def_rate_next  = def_rate_reg;
        wb_next        = wb_reg;
        req_next       = req_reg;
        err_next       = err_reg;
        slw_next       = slw_reg;
        cur_next       = cur_reg;
        target_next    = target_reg;
        m_valid_next   = m_valid_reg;
        cnt_next       = cnt_reg;
        ts_next        = ts_reg;
        latency_next   = latency_reg;
        rnd_next       = rnd_reg;
        err_flag_next  = err_flag_reg;
        slow_flag_next = slow_flag_reg;
        elapsed_next   = elapsed_reg;
        roll_next      = roll_reg;
        low_lt_next    = low_lt_reg;
        med_lt_next    = med_lt_reg;
        lat_hi_next    = lat_hi_reg;
        num_next       = num_reg;
        div_next       = div_reg;
        slow20_next    = slow20_reg;
        pct_next       = pct_reg;
        eff_next       = eff_reg;
        rem_next       = rem_reg;
        sampled_next   = sampled_reg;
        upd_next       = upd_reg;
        old_next       = old_reg;
        new_next       = new_reg;
        qps_next       = qps_reg;
        res_pct_next   = res_pct_reg;
        reason_next    = reason_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        nr       = cur_reg;
        rsn      = asrc_pkg::REASON_NONE;
        has      = 1'b0;
        qps_ext  = UW'(req_reg);
        req_base = roll_reg ? '0 : req_reg;
        err_base = roll_reg ? '0 : err_reg;
        slw_base = roll_reg ? '0 : slw_reg;
        cur_new  = roll_reg ? target_reg : cur_reg;
        rem_new  = borrow ? rem_sh[RW-1:0] : udiff[RW-1:0];

        if (cfg_we) begin
            case (cfg_index)
                asrc_pkg::CFG_WINDOW_LENGTH: wlen_next     = cfg_data;
                asrc_pkg::CFG_LOW_QPS:       low_next      = cfg_data;
                asrc_pkg::CFG_MEDIUM_QPS:    med_next      = cfg_data;
                asrc_pkg::CFG_ERROR_PCT:     pct_lim_next  = cfg_data[asrc_pkg::PCT_W-1:0];
                asrc_pkg::CFG_SLOW_LATENCY:  slow_lat_next = cfg_data;
                asrc_pkg::CFG_DEFAULT_RATE:  def_rate_next = cfg_data[RW-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ts_next = s_tdata[asrc_pkg::TS_LSB +: asrc_pkg::TS_W];
                    latency_next = s_tdata[asrc_pkg::LAT_LSB +: asrc_pkg::LAT_W];
                    rnd_next = s_tdata[asrc_pkg::RAND_LSB +: asrc_pkg::RAND_W];
                    err_flag_next = s_tdata[asrc_pkg::STATUS_LSB +: asrc_pkg::STATUS_W]
                                    >= asrc_pkg::STATUS_ERROR;
                    upd_next     = 1'b0;
                    old_next     = '0;
                    new_next     = '0;
                    qps_next     = '0;
                    res_pct_next = '0;
                    reason_next  = asrc_pkg::REASON_NONE;
                    state_next   = ST_SLOW;
                end
            end
            ST_SLOW: begin
                slow_flag_next = borrow;
                state_next     = ST_ELAPSE;
            end
            ST_ELAPSE: begin
                elapsed_next = udiff[asrc_pkg::TS_W-1:0];
                state_next   = ST_ROLL;
            end
            ST_ROLL: begin
                roll_next  = (wb_reg == '0) || borrow;
                state_next = ((wb_reg != '0) && borrow) ? ST_LOWCMP : ST_COUNT;
            end
            ST_LOWCMP: begin
                low_lt_next = borrow;
                state_next  = ST_MEDCMP;
            end
            ST_MEDCMP: begin
                med_lt_next = borrow;
                state_next  = ST_PREP;
            end
            ST_PREP: begin
                num_next    = UW'(err_reg) * UW'(asrc_pkg::PCT_SCALE);
                slow20_next = UW'(slw_reg) * UW'(asrc_pkg::LAT_SCALE);
                div_next    = UW'(req_reg) << (asrc_pkg::PCT_W - 1);
                pct_next    = '0;
                cnt_next    = CNT_W'(asrc_pkg::PCT_W - 1);
                // an empty window reports zero percent
                state_next  = (req_reg == '0) ? ST_LAT : ST_DIV;
            end
            ST_DIV: begin
                if (!borrow) begin
                    num_next = udiff[UW-1:0];
                end
                pct_next = {pct_reg[asrc_pkg::PCT_W-2:0], ~borrow};
                div_next = div_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_LAT;
                end
            end
            ST_LAT: begin
                lat_hi_next = borrow;
                state_next  = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (low_lt_reg) begin
                    if (cur_reg != asrc_pkg::RATE_ALL) begin
                        nr  = asrc_pkg::RATE_ALL;
                        rsn = asrc_pkg::REASON_LOW_QPS;
                        has = 1'b1;
                    end
                end else if (med_lt_reg) begin
                    if (cur_reg != asrc_pkg::RATE_TENTH) begin
                        nr  = asrc_pkg::RATE_TENTH;
                        rsn = asrc_pkg::REASON_MED_QPS;
                        has = 1'b1;
                    end
                end else if (pct_reg > pct_lim_reg) begin
                    if (cur_reg > asrc_pkg::RATE_TENTH) begin
                        nr  = asrc_pkg::RATE_TENTH;
                        rsn = asrc_pkg::REASON_ERRORS;
                        has = 1'b1;
                    end
                end else if (cur_reg != asrc_pkg::RATE_SPARSE) begin
                    nr  = asrc_pkg::RATE_SPARSE;
                    rsn = asrc_pkg::REASON_NONE;
                    has = 1'b1;
                end
                if (lat_hi_reg && (nr > asrc_pkg::RATE_TENTH)) begin
                    nr  = asrc_pkg::RATE_TENTH;
                    rsn = asrc_pkg::REASON_LATENCY;
                    has = 1'b1;
                end
                if (has && (nr != cur_reg)) begin
                    upd_next     = 1'b1;
                    old_next     = cur_reg;
                    new_next     = nr;
                    qps_next     = (|qps_ext[UW-1:asrc_pkg::QPS_W]) ?
                                   '1 : qps_ext[asrc_pkg::QPS_W-1:0];
                    res_pct_next = pct_reg;
                    reason_next  = rsn;
                end
                target_next = nr;
                state_next  = ST_COUNT;
            end
            ST_COUNT: begin
                if (roll_reg) begin
                    wb_next  = ts_reg;
                    cur_next = target_reg;
                end
                req_next = (req_base == '1) ? req_base : req_base + CW'(1);
                err_next = err_base;
                slw_next = slw_base;
                if (err_flag_reg) begin
                    err_next = (err_base == '1) ? err_base : err_base + CW'(1);
                end
                if (slow_flag_reg) begin
                    slw_next = (slw_base == '1) ? slw_base : slw_base + CW'(1);
                end
                eff_next = (cur_new != '0) ? cur_new : def_rate_reg;
                rem_next = '0;
                cnt_next = CNT_W'(asrc_pkg::RAND_W - 1);
                if (err_flag_reg || slow_flag_reg) begin
                    sampled_next = 1'b1;
                    state_next   = ST_DONE;
                end else if ((cur_new == '0) && (def_rate_reg == '0)) begin
                    sampled_next = 1'b0;
                    state_next   = ST_DONE;
                end else begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                // one remainder bit per cycle, random word MSB first
                rem_next = rem_new;
                rnd_next = rnd_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    sampled_next = (rem_new == '0);
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_data_next = '0;
                    m_data_next[asrc_pkg::SAMPLED_LSB] = sampled_reg;
                    m_data_next[asrc_pkg::OLD_LSB +: RW] = old_reg;
                    m_data_next[asrc_pkg::NEW_LSB +: RW] = new_reg;
                    m_data_next[asrc_pkg::QPS_LSB +: asrc_pkg::QPS_W] = qps_reg;
                    m_data_next[asrc_pkg::PCT_LSB +: asrc_pkg::PCT_W] = res_pct_reg;
                    m_data_next[asrc_pkg::REASON_LSB +: asrc_pkg::REASON_W] = reason_reg;
                    m_user_next  = upd_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wlen_reg     <= asrc_pkg::RST_WINDOW_LENGTH;
            low_reg      <= asrc_pkg::RST_LOW_QPS;
            med_reg      <= asrc_pkg::RST_MEDIUM_QPS;
            pct_lim_reg  <= asrc_pkg::RST_ERROR_PCT;
            slow_lat_reg <= asrc_pkg::RST_SLOW_LATENCY;
            def_rate_reg <= asrc_pkg::RST_DEFAULT_RATE;
            wb_reg       <= '0;
            req_reg      <= '0;
            err_reg      <= '0;
            slw_reg      <= '0;
            cur_reg      <= '0;
            target_reg   <= '0;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            wlen_reg     <= wlen_next;
            low_reg      <= low_next;
            med_reg      <= med_next;
            pct_lim_reg  <= pct_lim_next;
            slow_lat_reg <= slow_lat_next;
            def_rate_reg <= def_rate_next;
            wb_reg       <= wb_next;
            req_reg      <= req_next;
            err_reg      <= err_next;
            slw_reg      <= slw_next;
            cur_reg      <= cur_next;
            target_reg   <= target_next;
            m_valid_reg  <= m_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ts_reg        <= ts_next;
        latency_reg   <= latency_next;
        rnd_reg       <= rnd_next;
        err_flag_reg  <= err_flag_next;
        slow_flag_reg <= slow_flag_next;
        elapsed_reg   <= elapsed_next;
        roll_reg      <= roll_next;
        low_lt_reg    <= low_lt_next;
        med_lt_reg    <= med_lt_next;
        lat_hi_reg    <= lat_hi_next;
        num_reg       <= num_next;
        div_reg       <= div_next;
        slow20_reg    <= slow20_next;
        pct_reg       <= pct_next;
        eff_reg       <= eff_next;
        rem_reg       <= rem_next;
        sampled_reg   <= sampled_next;
        upd_reg       <= upd_next;
        old_reg       <= old_next;
        new_reg       <= new_next;
        qps_reg       <= qps_next;
        res_pct_reg   <= res_pct_next;
        reason_reg    <= reason_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

endmodule

/* sim/adaptive_sample_rate_controller_top_tb.sv */
// ----------------------------------------------------------------------------
// adaptive_sample_rate_controller_top_tb
// Self-checking bench for the adaptive sample rate controller. A short table
// of requests opens the run (reset defaults, unset window, boundaries,
// timestamp wrap). Randomized phases follow, each with its own register
// setting. Timestamps are mostly walked forward so that windows fill and roll
// over, and some of them wrap, go back, are zero or are forced to a window
// boundary. Every accepted request is run through an in-bench model of the
// window logic, and each returned decision is compared field by field.
// ----------------------------------------------------------------------------
module adaptive_sample_rate_controller_top_tb;

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned LIMIT_CYCLES = 2000000;
    localparam int unsigned TAIL_CYCLES  = 64;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int NUM_REGS        = 6;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 158;
    localparam int HOLD_PHASE      = 2;
    localparam int PAUSE_PHASE     = 5;
    localparam logic [63:0] COUNT_MAX = 64'hFFFF_FFFF;

    typedef struct packed {
        logic                          sampled;
        logic                          rate_update;
        logic [asrc_pkg::RATE_W-1:0]   old_rate;
        logic [asrc_pkg::RATE_W-1:0]   chosen_rate;
        logic [asrc_pkg::QPS_W-1:0]    window_qps;
        logic [asrc_pkg::PCT_W-1:0]    error_percent;
        logic [asrc_pkg::REASON_W-1:0] reason_code;
    } decision_t;

    typedef struct packed {
        logic [asrc_pkg::TS_W-1:0]     ts;
        logic [asrc_pkg::LAT_W-1:0]    lat;
        logic [asrc_pkg::STATUS_W-1:0] status;
        logic [asrc_pkg::RAND_W-1:0]   rnd;
        logic                          typed;
        decision_t                     want;
    } opening_row_t;

    localparam decision_t PICKED  =
        '{1'b1, 1'b0, 7'd0, 7'd0, 32'd0, 7'd0, asrc_pkg::REASON_NONE};
    localparam decision_t SKIPPED =
        '{1'b0, 1'b0, 7'd0, 7'd0, 32'd0, 7'd0, asrc_pkg::REASON_NONE};
    // three requests in the first window, one error, one slow: 33 percent
    localparam decision_t FIRST_JUDGED =
        '{1'b1, 1'b1, 7'd0, asrc_pkg::RATE_ALL, 32'd3, 7'd33, asrc_pkg::REASON_LOW_QPS};
    localparam int NUM_OPENING = 16;

    // unset window, reset defaults, threshold edges, first rollover, wrap
    opening_row_t opening_rows [NUM_OPENING] = '{
        '{64'd0, 64'd0, 10'd200, 32'd0, 1'b1, PICKED},
        '{64'd0, 64'd0, 10'd200, 32'd1, 1'b1, SKIPPED},
        '{64'd0, 64'd0, 10'd999, 32'd1, 1'b1, PICKED},
        '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0, 32'd1, 1'b1, PICKED},
        '{64'd1000, 64'd1000000000, 10'd399, 32'd200, 1'b1, PICKED},
        '{64'd1000, 64'd1000000001, 10'd200, 32'd3, 1'b1, PICKED},
        '{64'd1000001000, 64'd0, 10'd400, 32'd3, 1'b1, PICKED},
        '{64'd1000001001, 64'd0, 10'd200, 32'd3, 1'b1, FIRST_JUDGED},
        '{64'hFFFF_FFFF_FFFF_FFF0, 64'd0, 10'd0, 32'hFFFF_FFFF, 1'b0, SKIPPED},
        '{64'd5, 64'd999999999, 10'd999, 32'd0, 1'b0, SKIPPED},
        '{64'd6, 64'hFFFF_FFFF_0000_0000, 10'd512, 32'hAAAA_AAAA, 1'b0, SKIPPED},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555, 10'd1, 32'h5555_5555,
          1'b0, SKIPPED},
        '{64'd0, 64'd7, 10'd450, 32'd100, 1'b0, SKIPPED},
        '{64'h8000_0000_0000_0000, 64'd1, 10'd300, 32'h8000_0000, 1'b0, SKIPPED},
        '{64'h8000_0000_3B9A_CA01, 64'd0, 10'd200, 32'hFFFF_FFFF, 1'b0, SKIPPED},
        '{64'h8000_0000_3B9A_CA01, 64'd0, 10'd200, 32'd10, 1'b0, SKIPPED}
    };

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [asrc_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [asrc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tuser;
    logic                            cfg_we    = 1'b0;
    logic [asrc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [asrc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // model copy of the registers and the window state
    logic [31:0]                 reg_window_len, reg_low_qps, reg_med_qps, reg_slow_lat;
    logic [asrc_pkg::PCT_W-1:0]  reg_err_limit;
    logic [asrc_pkg::RATE_W-1:0] reg_dflt_rate;
    logic [63:0]                 win_start, req_cnt, err_cnt, slow_cnt;
    logic [asrc_pkg::RATE_W-1:0] cur_rate, tgt_rate;

    decision_t expected_decisions [$];

    // request shaping of the current phase
    logic [63:0] ts_cursor;
    int unsigned step_max;
    int unsigned err_share, slow_share;
    int unsigned src_idle_pct, sink_idle_pct;
    int unsigned free_run;

    int unsigned holds_asked, holds_granted, sink_hold_left, sink_gap_left;
    int unsigned requests_sent, results_seen, samples_seen, updates_seen;
    int unsigned mismatch_count;
    logic [7:0]  reasons_seen = '0;

    adaptive_sample_rate_controller_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void reset_model();
        reg_window_len = asrc_pkg::RST_WINDOW_LENGTH;
        reg_low_qps    = asrc_pkg::RST_LOW_QPS;
        reg_med_qps    = asrc_pkg::RST_MEDIUM_QPS;
        reg_err_limit  = asrc_pkg::RST_ERROR_PCT;
        reg_slow_lat   = asrc_pkg::RST_SLOW_LATENCY;
        reg_dflt_rate  = asrc_pkg::RST_DEFAULT_RATE;
        win_start = '0;
        req_cnt   = '0;
        err_cnt   = '0;
        slow_cnt  = '0;
        cur_rate  = '0;
        tgt_rate  = '0;
    endfunction

    function automatic void apply_reg(input logic [asrc_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [31:0] val);
        case (idx)
            asrc_pkg::CFG_WINDOW_LENGTH: reg_window_len = val;
            asrc_pkg::CFG_LOW_QPS:       reg_low_qps    = val;
            asrc_pkg::CFG_MEDIUM_QPS:    reg_med_qps    = val;
            asrc_pkg::CFG_ERROR_PCT:     reg_err_limit  = val[asrc_pkg::PCT_W-1:0];
            asrc_pkg::CFG_SLOW_LATENCY:  reg_slow_lat   = val;
            asrc_pkg::CFG_DEFAULT_RATE:  reg_dflt_rate  = val[asrc_pkg::RATE_W-1:0];
            default: ;
        endcase
    endfunction

    // advance the window state by one request and return the decision it gets
    function automatic decision_t judge_request(input logic [63:0] ts, input logic [63:0] lat,
                                                input logic [asrc_pkg::STATUS_W-1:0] status,
                                                input logic [31:0] rnd);
        decision_t                   d;
        logic                        is_err, is_slow, has_reason;
        logic [asrc_pkg::RATE_W-1:0] nr, eff;
        logic [63:0]                 qps, pct;
        d = SKIPPED;
        is_err  = status >= asrc_pkg::STATUS_ERROR;
        is_slow = lat > {32'd0, reg_slow_lat};
        if (win_start == 64'd0 || (ts - win_start) > {32'd0, reg_window_len}) begin
            if (win_start != 64'd0) begin
                qps = req_cnt;
                pct = (qps != 0) ? (err_cnt * asrc_pkg::PCT_SCALE) / qps : 64'd0;
                nr = cur_rate;
                has_reason = 1'b0;
                d.reason_code = asrc_pkg::REASON_NONE;
                if (qps < {32'd0, reg_low_qps}) begin
                    if (nr != asrc_pkg::RATE_ALL) begin
                        nr = asrc_pkg::RATE_ALL;
                        d.reason_code = asrc_pkg::REASON_LOW_QPS;
                        has_reason = 1'b1;
                    end
                end else if (qps < {32'd0, reg_med_qps}) begin
                    if (nr != asrc_pkg::RATE_TENTH) begin
                        nr = asrc_pkg::RATE_TENTH;
                        d.reason_code = asrc_pkg::REASON_MED_QPS;
                        has_reason = 1'b1;
                    end
                end else if (pct > {57'd0, reg_err_limit}) begin
                    if (nr > asrc_pkg::RATE_TENTH) begin
                        nr = asrc_pkg::RATE_TENTH;
                        d.reason_code = asrc_pkg::REASON_ERRORS;
                        has_reason = 1'b1;
                    end
                end else if (nr != asrc_pkg::RATE_SPARSE) begin
                    nr = asrc_pkg::RATE_SPARSE;
                    d.reason_code = asrc_pkg::REASON_NONE;
                    has_reason = 1'b1;
                end
                if (slow_cnt * asrc_pkg::LAT_SCALE > qps && nr > asrc_pkg::RATE_TENTH) begin
                    nr = asrc_pkg::RATE_TENTH;
                    d.reason_code = asrc_pkg::REASON_LATENCY;
                    has_reason = 1'b1;
                end
                if (nr != cur_rate && has_reason) begin
                    d.rate_update   = 1'b1;
                    d.old_rate      = cur_rate;
                    d.chosen_rate   = nr;
                    d.window_qps    = qps[asrc_pkg::QPS_W-1:0];
                    d.error_percent = pct[asrc_pkg::PCT_W-1:0];
                end else begin
                    d.reason_code = asrc_pkg::REASON_NONE;
                end
                tgt_rate = nr;
            end
            win_start = ts;
            req_cnt   = '0;
            err_cnt   = '0;
            slow_cnt  = '0;
            cur_rate  = tgt_rate;
        end
        if (req_cnt != COUNT_MAX) req_cnt++;
        if (is_err && err_cnt != COUNT_MAX) err_cnt++;
        if (is_slow && slow_cnt != COUNT_MAX) slow_cnt++;
        if (is_err || is_slow) begin
            d.sampled = 1'b1;
        end else begin
            eff = (cur_rate != 0) ? cur_rate : reg_dflt_rate;
            d.sampled = (eff != 0) && ((rnd % {25'd0, eff}) == 32'd0);
        end
        return d;
    endfunction

    task automatic note_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
        $display("MISMATCH at result %0d, %s: expected %0d, got %0d",
                 results_seen, field, want, got);
        mismatch_count++;
    endtask

    task automatic check_result(input logic [asrc_pkg::M_TDATA_W-1:0] word,
                                input logic flag);
        decision_t want, got;
        got.sampled       = word[asrc_pkg::SAMPLED_LSB];
        got.rate_update   = flag;
        got.old_rate      = word[asrc_pkg::OLD_LSB +: asrc_pkg::RATE_W];
        got.chosen_rate   = word[asrc_pkg::NEW_LSB +: asrc_pkg::RATE_W];
        got.window_qps    = word[asrc_pkg::QPS_LSB +: asrc_pkg::QPS_W];
        got.error_percent = word[asrc_pkg::PCT_LSB +: asrc_pkg::PCT_W];
        got.reason_code   = word[asrc_pkg::REASON_LSB +: asrc_pkg::REASON_W];
        results_seen++;
        if (got.sampled) samples_seen++;
        if (got.rate_update) begin
            updates_seen++;
            reasons_seen[got.reason_code] = 1'b1;
        end
        if (expected_decisions.size() == 0) begin
            note_mismatch("decision with no request pending", 0, word);
            return;
        end
        want = expected_decisions.pop_front();
        if (got.sampled != want.sampled)
            note_mismatch("sampled", want.sampled, got.sampled);
        if (got.rate_update != want.rate_update)
            note_mismatch("rate_update", want.rate_update, got.rate_update);
        if (got.old_rate != want.old_rate)
            note_mismatch("old_rate", want.old_rate, got.old_rate);
        if (got.chosen_rate != want.chosen_rate)
            note_mismatch("chosen_rate", want.chosen_rate, got.chosen_rate);
        if (got.window_qps != want.window_qps)
            note_mismatch("window_qps", want.window_qps, got.window_qps);
        if (got.error_percent != want.error_percent)
            note_mismatch("error_percent", want.error_percent, got.error_percent);
        if (got.reason_code != want.reason_code)
            note_mismatch("reason_code", want.reason_code, got.reason_code);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata, m_tuser);
    end

    // receiver: long hold on request, otherwise short random stalls
    always @(posedge aclk) begin
        if (holds_granted != holds_asked) begin
            holds_granted  = holds_asked;
            sink_hold_left = LONG_HOLD;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_hold_left > 0) begin
            sink_hold_left--;
            m_tready <= 1'b0;
        end else if (sink_gap_left > 0) begin
            sink_gap_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            sink_gap_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic [63:0] ts, input logic [63:0] lat,
                                input logic [asrc_pkg::STATUS_W-1:0] status,
                                input logic [31:0] rnd,
                                input logic typed, input decision_t typed_want);
        logic [asrc_pkg::S_TDATA_W-1:0] word;
        decision_t                      d;
        word = '0;
        word[asrc_pkg::TS_LSB +: asrc_pkg::TS_W]         = ts;
        word[asrc_pkg::LAT_LSB +: asrc_pkg::LAT_W]       = lat;
        word[asrc_pkg::STATUS_LSB +: asrc_pkg::STATUS_W] = status;
        word[asrc_pkg::RAND_LSB +: asrc_pkg::RAND_W]     = rnd;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        d = judge_request(ts, lat, status, rnd);
        expected_decisions.push_back(typed ? typed_want : d);
        requests_sent++;
    endtask

    task automatic maybe_pause();
        if (free_run > 0) begin
            free_run--;
        end else if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // drop valid and hold until every pending decision has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_decisions.size() != 0) @(posedge aclk);
    endtask

    task automatic program_phase(input int p);
        logic [31:0] vals [NUM_REGS];
        logic [31:0] win, lo, med, pct, slow, dflt;
        case (p)
            0: begin
                win = 32'd1; lo = 32'd0; med = 32'd0;
                pct = 32'd0; slow = 32'd0; dflt = 32'd1;
            end
            1: begin
                win = '1; lo = '1; med = '1;
                pct = '1; slow = '1; dflt = '1;
            end
            2: begin
                win = asrc_pkg::RST_WINDOW_LENGTH;
                lo = asrc_pkg::RST_LOW_QPS;
                med = asrc_pkg::RST_MEDIUM_QPS;
                pct = 32'(asrc_pkg::RST_ERROR_PCT);
                slow = asrc_pkg::RST_SLOW_LATENCY;
                dflt = 32'(asrc_pkg::RST_DEFAULT_RATE);
            end
            3: begin
                win = $urandom_range(16, 200); lo = 32'd2; med = 32'd6;
                pct = 32'd100; slow = 32'd500; dflt = 32'd0;
            end
            default: begin
                win  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'hFFFF_FFFF)
                                                   : $urandom_range(16, 600);
                lo   = $urandom_range(0, 10);
                med  = $urandom_range(0, 24);
                pct  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100);
                slow = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
                dflt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 100);
            end
        endcase
        vals[asrc_pkg::CFG_WINDOW_LENGTH] = win;
        vals[asrc_pkg::CFG_LOW_QPS]       = lo;
        vals[asrc_pkg::CFG_MEDIUM_QPS]    = med;
        vals[asrc_pkg::CFG_ERROR_PCT]     = pct;
        vals[asrc_pkg::CFG_SLOW_LATENCY]  = slow;
        vals[asrc_pkg::CFG_DEFAULT_RATE]  = dflt;
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= asrc_pkg::CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            apply_reg(asrc_pkg::CFG_IDX_W'(i), vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        step_max = win / $urandom_range(2, 24);
        if (step_max == 0) step_max = 1;
        err_share  = $urandom_range(0, 45);
        slow_share = $urandom_range(0, 45);
        if (p == NUM_PHASES - 1 || p % 4 == 1) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end else begin
            src_idle_pct  = $urandom_range(5, 35);
            sink_idle_pct = $urandom_range(5, 35);
        end
        ts_cursor = {$urandom, $urandom};
    endtask

    // mostly forward-walking timestamps; some wrap, go back, zero or hit a boundary
    task automatic make_request(output logic [63:0] ts, output logic [63:0] lat,
                                output logic [asrc_pkg::STATUS_W-1:0] status,
                                output logic [31:0] rnd);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        rnd  = $urandom;
        if ($urandom_range(0, 99) < err_share)
            status = 10'($urandom_range(400, 999));
        else
            status = 10'($urandom_range(0, 399));
        if ($urandom_range(0, 99) < slow_share) begin
            if ($urandom_range(0, 2) == 0)
                lat = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
            else
                lat = {32'd0, reg_slow_lat} + 64'd1 + 64'($urandom_range(0, 1000));
        end else begin
            lat = 64'($urandom_range(0, reg_slow_lat));
        end
        if (pick < 72)
            ts = ts_cursor + 64'($urandom_range(0, step_max));
        else if (pick < 84)
            ts = ts_cursor + {32'd0, reg_window_len} + 64'd1 + 64'($urandom_range(0, step_max));
        else if (pick < 88)
            ts = win_start + {32'd0, reg_window_len} + 64'($urandom_range(0, 1));
        else if (pick < 91)
            ts = 64'd0;
        else if (pick < 94)
            ts = ts_cursor - 64'($urandom_range(1, step_max));
        else if (pick < 97)
            ts = {$urandom, $urandom};
        else begin
            ts     = {$urandom, $urandom};
            lat    = {$urandom, $urandom};
            status = 10'($urandom_range(0, 999));
        end
        if (ts != 64'd0) ts_cursor = ts;
    endtask

    initial begin : run_limit
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("adaptive_sample_rate_controller_top verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [63:0]                   ts, lat;
        logic [asrc_pkg::STATUS_W-1:0] status;
        logic [31:0]                   rnd;
        reset_model();
        free_run = 0;
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_OPENING; i++) begin
            send_request(opening_rows[i].ts, opening_rows[i].lat, opening_rows[i].status,
                         opening_rows[i].rnd, opening_rows[i].typed, opening_rows[i].want);
            maybe_pause();
        end
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_phase(p);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                make_request(ts, lat, status, rnd);
                send_request(ts, lat, status, rnd, 1'b0, SKIPPED);
                if (p == HOLD_PHASE && k == 40) begin
                    // stall the receiver and keep offering so the input backs up
                    holds_asked++;
                    free_run = 40;
                end
                if (p == PAUSE_PHASE && k == 80)
                    settle();
                else
                    maybe_pause();
            end
            settle();
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d requests over %0d register settings;", requests_sent,
                 NUM_PHASES + 1);
        $display("%0d decisions checked, %0d sampled, %0d rate changes, reasons %b, %0d mismatches",
                 results_seen, samples_seen, updates_seen, reasons_seen[4:0], mismatch_count);
        if (mismatch_count == 0)
            $display("adaptive_sample_rate_controller_top verification clean");
        else
            $display("adaptive_sample_rate_controller_top verification failed");
        $finish;
    end

endmodule
